// ----- rtl/btt_pkg.sv -----
// shared types, constants and byte classification for the byte tokenizer
package btt_pkg;

	localparam int HIST_DEPTH = 3;
	localparam int HIST_CNT_W = 2;
	localparam int MAX_TOKEN_LEN_DEF = 255;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 2;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 2;

	// register indexes on the config port
	localparam logic [CFG_ADDR_W-1:0] CFG_SEP_LOW  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SEP_HIGH = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_LOWER    = 2'd2;

	// token kinds
	localparam logic [1:0] KIND_TERM  = 2'd0;
	localparam logic [1:0] KIND_OPEN  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CASE_DIFF = 8'd32;
	localparam logic [7:0] CTRL_LAST = 8'd31;
	localparam logic [7:0] CH_DEL    = 8'd127;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] sep_map_low;
		logic [CFG_DATA_W-1:0] sep_map_high;
		logic                  lowercase_mode;
	} cfg_t;

	function automatic logic is_separator(input logic [7:0] c, input cfg_t cfg);
		logic [2*CFG_DATA_W-1:0] map;
		map = {cfg.sep_map_high, cfg.sep_map_low};
		if (c <= CTRL_LAST || c >= CH_DEL) begin
			return 1'b1;
		end
		return map[c[6:0]];
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c, input logic lower);
		if (lower && c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			return c + CASE_DIFF;
		end
		return c;
	endfunction

endpackage

// ----- rtl/btt_cfg.sv -----
// configuration registers: delimiter maps and case folding mode
module btt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [btt_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [btt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output btt_pkg::cfg_t                 cfg
);
	import btt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sep_map_low    <= '0;
			cfg_q.sep_map_high   <= '0;
			cfg_q.lowercase_mode <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_SEP_LOW:  cfg_q.sep_map_low    <= cfg_wdata;
				CFG_SEP_HIGH: cfg_q.sep_map_high   <= cfg_wdata;
				CFG_LOWER:    cfg_q.lowercase_mode <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/btt_engine.sv -----
// input register, token and separator history state, result register
module btt_engine #(
	parameter int MAX_TOKEN_LEN = btt_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  btt_pkg::cfg_t                 cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [btt_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [btt_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [btt_pkg::M_TUSER_W-1:0] m_tuser
);
	import btt_pkg::*;

	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// tokenizer state
	logic [7:0]            hist_q [HIST_DEPTH];
	logic [7:0]            hist_d [HIST_DEPTH];
	logic [HIST_CNT_W-1:0] cnt_q, cnt_d;
	logic [LEN_W-1:0]      len_q, len_d;

	// result register
	logic       out_valid_q;
	logic [7:0] char_q, length_q;
	logic       in_tok_q, done_q, dropped_q;
	logic [1:0] kind_q;

	logic       adv;
	logic       sep;
	logic [7:0] ch, length, second, third;
	logic       in_tok, done, dropped;
	logic [1:0] kind;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign sep      = is_separator(byte_s1, cfg);

	// second and third entries below the '>' once it is pushed
	always_comb begin
		case (cnt_q)
			2'd0: begin
				second = '0;
				third  = '0;
			end
			2'd1: begin
				second = hist_q[0];
				third  = '0;
			end
			2'd2: begin
				second = hist_q[1];
				third  = hist_q[0];
			end
			default: begin
				second = hist_q[2];
				third  = hist_q[1];
			end
		endcase
	end

	always_comb begin
		hist_d  = hist_q;
		cnt_d   = cnt_q;
		len_d   = len_q;
		ch      = '0;
		in_tok  = 1'b0;
		done    = 1'b0;
		kind    = KIND_TERM;
		length  = '0;
		dropped = 1'b0;
		if (end_s1) begin
			dropped = (len_q != '0);
			len_d   = '0;
			cnt_d   = '0;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_d[i] = '0;
			end
		end else if (sep) begin
			ch = byte_s1;
			// push, dropping the oldest entry when full
			if (cnt_q == HIST_CNT_W'(HIST_DEPTH)) begin
				hist_d[0] = hist_q[1];
				hist_d[1] = hist_q[2];
				hist_d[2] = byte_s1;
			end else begin
				hist_d[cnt_q] = byte_s1;
				cnt_d = cnt_q + 1'b1;
			end
			if (len_q != '0) begin
				done = 1'b1;
				if (byte_s1 == CH_GT) begin
					// three pops always empty the history
					cnt_d = '0;
					if (second == CH_LT) begin
						kind = KIND_OPEN;
					end else if (second == CH_SLASH && third == CH_LT) begin
						kind = KIND_CLOSE;
					end
				end
				if (32'(len_q) > 32'd255) begin
					length = 8'hFF;
				end else begin
					length = 8'(len_q);
				end
				len_d = '0;
			end
		end else begin
			ch     = fold_case(byte_s1, cfg.lowercase_mode);
			in_tok = 1'b1;
			if (len_q < LEN_MAX) begin
				len_d = len_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			end_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			cnt_q <= '0;
			len_q <= '0;
		end else if (adv) begin
			hist_q <= hist_d;
			cnt_q  <= cnt_d;
			len_q  <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q    <= ch;
			in_tok_q  <= in_tok;
			done_q    <= done;
			kind_q    <= kind;
			length_q  <= length;
			dropped_q <= dropped;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, dropped_q, length_q, done_q, in_tok_q, char_q};
	assign m_tuser  = kind_q;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> cnt_q == '0 && len_q == '0)
		else $error("stream end did not clear history and length");

	a_done_not_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> !in_tok_q && !dropped_q)
		else $error("finished token word also marks a token byte or drop");

	a_kind_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_TERM |-> done_q && char_q == CH_GT)
		else $error("tag kind without a finishing '>'");

	a_len_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> done_q == (length_q != '0))
		else $error("token length disagrees with token_done");

endmodule

// ----- rtl/byte_tokenizer_with_tag_detect.sv -----
// top level of the byte tokenizer with tag detection
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | one byte of text per word, tlast = end of stream
//  m_*      | out       | one result word per input word, tuser = token kind
//  cfg_*    | in        | register writes, no read-back
//
// one word enters per cycle while the output is not stalled; its result passes
// through the input register, then the result register, and the state is updated as the word moves between them
// reset clears the history, the token length and the delimiter maps and turns case folding on
// a stalled output holds its word while one more input word waits in the
// input register; further input is refused until the output drains
module byte_tokenizer_with_tag_detect #(
	parameter int MAX_TOKEN_LEN = btt_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [btt_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] byte_in
	input  logic                          s_tlast,   // stream_end
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] char_out, [8] char_in_token, [9] token_done, [17:10] token_length,
	// [18] token_dropped, [23:19] zero
	output logic [btt_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [btt_pkg::M_TUSER_W-1:0] m_tuser,   // [1:0] token_kind
	input  logic                          cfg_we,
	input  logic [btt_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [btt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import btt_pkg::*;

	cfg_t cfg;

	btt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	btt_engine #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the byte tokenizer with tag detection
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import btt_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_MAX = 10;
	localparam int PHASE_WORDS = 180;
	localparam int LONG_TOKEN = 270;
	localparam logic [7:0] CH_SPACE = 8'h20;
	// space, slash, less-than and greater-than as delimiters
	localparam logic [63:0] TAG_SEPS = 64'h5000_8001_0000_0000;

	typedef struct packed {
		logic [7:0] ch;
		logic       in_tok;
		logic       done;
		logic [1:0] kind;
		logic [7:0] len;
		logic       dropped;
	} tok_result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
	} text_word_t;

	typedef struct packed {
		logic        has_lit;
		tok_result_t want;
	} word_note_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        e;
		logic        has_lit;
		tok_result_t want;
	} dir_row_t;

	localparam tok_result_t ZERO_WORD = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// tokenizer state and registers as the checker sees them
	logic [63:0] map_low;
	logic [63:0] map_high;
	logic        fold_on;
	logic [7:0]  hist [HIST_DEPTH];
	int          hist_cnt;
	int          tok_len;

	word_note_t  word_notes[$];
	tok_result_t expected_words[$];
	text_word_t  text_bytes[$];

	int  errors = 0;
	int  cycle_count = 0;
	bit  hold_req = 1'b0;
	bit  calm = 1'b0;

	dir_row_t script [25] = '{
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, KIND_TERM, 8'd0, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, KIND_TERM, 8'd0, 1'b0}},
		'{8'h41, 1'b0, 1'b1, '{8'h61, 1'b1, 1'b0, KIND_TERM, 8'd0, 1'b0}},
		'{8'h5A, 1'b0, 1'b0, ZERO_WORD},
		'{CH_GT, 1'b0, 1'b1, '{CH_GT, 1'b0, 1'b1, KIND_TERM, 8'd2, 1'b0}},
		'{CH_LT, 1'b0, 1'b0, ZERO_WORD},
		'{8'h61, 1'b0, 1'b0, ZERO_WORD},
		'{CH_GT, 1'b0, 1'b0, ZERO_WORD},
		'{CH_LT, 1'b0, 1'b0, ZERO_WORD},
		'{CH_SLASH, 1'b0, 1'b0, ZERO_WORD},
		'{8'h62, 1'b0, 1'b0, ZERO_WORD},
		'{CH_GT, 1'b0, 1'b0, ZERO_WORD},
		'{CH_SLASH, 1'b0, 1'b0, ZERO_WORD},
		'{8'h78, 1'b0, 1'b0, ZERO_WORD},
		'{CH_GT, 1'b0, 1'b0, ZERO_WORD},
		'{8'h7E, 1'b0, 1'b0, ZERO_WORD},
		'{8'h40, 1'b0, 1'b0, ZERO_WORD},
		'{CH_DEL, 1'b0, 1'b0, ZERO_WORD},
		'{8'h5B, 1'b0, 1'b0, ZERO_WORD},
		'{CH_SPACE, 1'b0, 1'b0, ZERO_WORD},
		'{8'h6D, 1'b0, 1'b0, ZERO_WORD},
		'{8'h51, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, KIND_TERM, 8'd0, 1'b1}},
		'{8'hFF, 1'b1, 1'b1, ZERO_WORD},
		'{8'h71, 1'b0, 1'b0, ZERO_WORD},
		'{CH_LT, 1'b0, 1'b0, ZERO_WORD}
	};

	byte_tokenizer_with_tag_detect uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit byte_is_delim(input logic [7:0] b);
		if (b <= CTRL_LAST || b >= CH_DEL) begin
			return 1'b1;
		end
		return b[6] ? map_high[b[5:0]] : map_low[b[5:0]];
	endfunction

	// an empty history pops as zero
	function automatic logic [7:0] pop_history();
		if (hist_cnt == 0) begin
			return 8'h00;
		end
		hist_cnt--;
		return hist[hist_cnt];
	endfunction

	function automatic tok_result_t tokenize_byte(input logic [7:0] b, input logic e);
		tok_result_t r;
		logic [7:0] second;
		logic [7:0] third;
		r = '0;
		if (e) begin
			r.dropped = (tok_len != 0);
			tok_len = 0;
			hist_cnt = 0;
			for (int i = 0; i < HIST_DEPTH; i++) hist[i] = 8'h00;
		end else if (byte_is_delim(b)) begin
			r.ch = b;
			// full history drops its oldest entry
			if (hist_cnt >= HIST_DEPTH) begin
				for (int i = 0; i + 1 < HIST_DEPTH; i++) hist[i] = hist[i+1];
				hist_cnt = HIST_DEPTH - 1;
			end
			hist[hist_cnt] = b;
			hist_cnt++;
			if (tok_len != 0) begin
				r.done = 1'b1;
				r.kind = KIND_TERM;
				if (b == CH_GT) begin
					void'(pop_history());
					second = pop_history();
					third = pop_history();
					if (second == CH_LT) begin
						r.kind = KIND_OPEN;
					end else if (second == CH_SLASH && third == CH_LT) begin
						r.kind = KIND_CLOSE;
					end
				end
				r.len = (tok_len > 255) ? 8'hFF : 8'(tok_len);
				tok_len = 0;
			end
		end else begin
			r.ch = (fold_on && b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_DIFF : b;
			r.in_tok = 1'b1;
			if (tok_len < MAX_TOKEN_LEN_DEF) begin
				tok_len++;
			end
		end
		return r;
	endfunction

	// input side predicts, output side compares with the oldest expected word
	always @(posedge clk) begin
		word_note_t  note;
		tok_result_t guess;
		tok_result_t got;
		tok_result_t want;
		if (arst_n && s_tvalid && s_tready) begin
			note = word_notes.pop_front();
			guess = tokenize_byte(s_tdata, s_tlast);
			expected_words.push_back(note.has_lit ? note.want : guess);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.ch = m_tdata[7:0];
			got.in_tok = m_tdata[8];
			got.done = m_tdata[9];
			got.len = m_tdata[17:10];
			got.dropped = m_tdata[18];
			got.kind = m_tuser;
			if (expected_words.size() == 0) begin
				if (errors < REPORT_MAX) begin
					$display("unexpected result word: tdata=%h tuser=%h", m_tdata, m_tuser);
				end
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (got.ch !== want.ch || got.in_tok !== want.in_tok ||
						got.done !== want.done || got.kind !== want.kind ||
						got.len !== want.len || got.dropped !== want.dropped) begin
					if (errors < REPORT_MAX) begin
						$display("mismatch: expected ch=%h in=%b done=%b kind=%0d len=%0d drop=%b",
							want.ch, want.in_tok, want.done, want.kind, want.len, want.dropped);
						$display("          got      ch=%h in=%b done=%b kind=%0d len=%0d drop=%b",
							got.ch, got.in_tok, got.done, got.kind, got.len, got.dropped);
					end
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request, none when calm
	initial begin
		m_tready = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 15) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic configure(input logic [63:0] low, input logic [63:0] high, input logic lower);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_SEP_LOW;
		cfg_wdata <= low;
		@(posedge clk);
		cfg_addr <= CFG_SEP_HIGH;
		cfg_wdata <= high;
		@(posedge clk);
		cfg_addr <= CFG_LOWER;
		cfg_wdata <= {63'd0, lower};
		@(posedge clk);
		cfg_we <= 1'b0;
		map_low = low;
		map_high = high;
		fold_on = lower;
	endtask

	task automatic send_word(input logic [7:0] b, input logic e, input logic has_lit,
			input tok_result_t want);
		word_notes.push_back('{has_lit, want});
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= e;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!calm && !hold_req && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0 || word_notes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] name_char();
		if ($urandom_range(0, 7) == 0) begin
			return 8'($urandom_range(33, 126));
		end
		return 8'($urandom_range(0, 1) ? 65 + $urandom_range(0, 25) : 97 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] sep_char();
		case ($urandom_range(0, 5))
			0, 1: return CH_SPACE;
			2: return 8'($urandom_range(0, 31));
			3: return 8'($urandom_range(127, 255));
			4: return CH_GT;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] tag_char();
		case ($urandom_range(0, 3))
			0: return CH_LT;
			1: return CH_SLASH;
			2: return CH_GT;
			default: return CH_SPACE;
		endcase
	endfunction

	// mostly tags and words with random content, some noise and broken input
	function automatic void build_text(input int target, input bit with_long);
		int pick;
		text_bytes.delete();
		if (with_long) begin
			// lower-case letters only so the token runs past the length limit unbroken
			repeat (LONG_TOKEN) text_bytes.push_back('{8'($urandom_range(97, 122)), 1'b0});
			text_bytes.push_back('{CH_SPACE, 1'b0});
		end
		while (text_bytes.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				text_bytes.push_back('{CH_LT, 1'b0});
				if ($urandom_range(0, 1)) text_bytes.push_back('{CH_SLASH, 1'b0});
				repeat ($urandom_range(1, 8)) text_bytes.push_back('{name_char(), 1'b0});
				text_bytes.push_back('{CH_GT, 1'b0});
			end else if (pick < 72) begin
				repeat ($urandom_range(1, 10)) text_bytes.push_back('{name_char(), 1'b0});
				text_bytes.push_back('{sep_char(), 1'b0});
			end else if (pick < 84) begin
				repeat ($urandom_range(1, 4))
					text_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0});
			end else if (pick < 92) begin
				repeat ($urandom_range(0, 3)) text_bytes.push_back('{name_char(), 1'b0});
				text_bytes.push_back('{8'($urandom_range(0, 255)), 1'b1});
			end else begin
				repeat ($urandom_range(1, 3)) text_bytes.push_back('{tag_char(), 1'b0});
				repeat ($urandom_range(0, 3)) text_bytes.push_back('{name_char(), 1'b0});
				text_bytes.push_back('{CH_GT, 1'b0});
			end
		end
	endfunction

	initial begin
		text_word_t w;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		map_low = '0;
		map_high = '0;
		fold_on = 1'b1;
		hist_cnt = 0;
		tok_len = 0;
		for (int i = 0; i < HIST_DEPTH; i++) hist[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(TAG_SEPS, 64'd0, 1'b1);
		foreach (script[i]) send_word(script[i].b, script[i].e, script[i].has_lit, script[i].want);
		drain();

		for (int phase = 1; phase <= 4; phase++) begin
			case (phase)
				1: configure({64{1'b1}}, 64'd0, 1'b0);
				2: configure(64'd0, {64{1'b1}}, 1'b1);
				3: configure({$urandom, $urandom} | TAG_SEPS,
					{$urandom, $urandom} & {$urandom, $urandom}, 1'($urandom_range(0, 1)));
				default: configure(TAG_SEPS, 64'd0, 1'b1);
			endcase
			build_text(PHASE_WORDS, phase == 1);
			// receiver holds off while the sender keeps offering words
			if (phase == 1) hold_req = 1'b1;
			if (phase == 4) calm = 1'b1;
			while (text_bytes.size() != 0) begin
				w = text_bytes.pop_front();
				send_word(w.b, w.e, 1'b0, ZERO_WORD);
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/btt_pkg.sv
rtl/btt_cfg.sv
rtl/btt_engine.sv
rtl/byte_tokenizer_with_tag_detect.sv
tb/sv/tb_top.sv
